[rtl/dda_pkg.sv]
// Shared types and command codes for the DDA line pixel generator.
package dda_pkg;

  // Command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Incoming request word
  typedef struct packed {
    logic               command;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [31:0]        line_color;
  } cmd_t;

  // Outgoing pixel word
  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [31:0]        pixel_color;
    logic               pixel_valid;
    logic               last_pixel;
  } pixel_t;

endpackage

[rtl/dda_line_pixel_generator.sv]
// DDA line pixel generator: loads a line, then emits one exact pixel per advance request.
//
// A load request (command CMD_LOAD) latches both endpoints and the colour and gives no
// result; each advance request (CMD_ADVANCE) gives exactly one pixel word, the pixels
// running from the start point to the end point inclusive, max(|dx|,|dy|)+1 of them,
// with last_pixel set on the end point. An advance with no line in progress, including
// after the last pixel or after a zero-length load, returns a word with pixel_valid low
// and all other fields zero. The integer/remainder accumulators update in a single
// pass and the pixel lands in the output register, so the block sustains one request
// per clock while the downstream side keeps taking pixels. cmd_ready drops only while the
// output register holds a pixel that the downstream side has not yet taken. Only the low
// COORD_BITS bits of each coordinate are used, read as two's complement, and outputs
// are sign-extended from that width.
module dda_line_pixel_generator
  import dda_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   cmd_valid,
  output logic   cmd_ready,
  input  cmd_t   cmd,
  output logic   pix_valid,
  input  logic   pix_ready,
  output pixel_t pix
);

  localparam int DW = COORD_BITS + 1;  // deltas and whole parts
  localparam int RW = COORD_BITS + 2;  // remainder sums and positions

  // Line state
  logic signed [COORD_BITS-1:0] origin_x, origin_y;
  logic signed [DW-1:0]         delta_x, delta_y;
  logic signed [DW-1:0]         whole_x, whole_y;
  logic [COORD_BITS-1:0]        rem_x, rem_y;
  logic [COORD_BITS-1:0]        step_total;
  logic [COORD_BITS-1:0]        pixel_index;
  logic                         line_active;
  logic [31:0]                  held_color;

  logic                         cmd_take;
  logic signed [COORD_BITS-1:0] ld_x0, ld_y0, ld_x1, ld_y1;
  logic signed [DW-1:0]         ld_dx, ld_dy, ld_ax, ld_ay;
  logic [COORD_BITS-1:0]        ld_step;
  logic signed [DW-1:0]         whole_x_next, whole_y_next;
  logic [COORD_BITS-1:0]        rem_x_next, rem_y_next;
  logic signed [RW-1:0]         pos_x, pos_y;
  logic                         is_last;
  pixel_t                       pix_next;

  // Step dx*i = whole*S + rem on to i+1; |delta| <= S keeps one correction enough
  function automatic void accum(
    input  logic signed [DW-1:0]         delta,
    input  logic signed [DW-1:0]         whole,
    input  logic [COORD_BITS-1:0]        rem,
    input  logic [COORD_BITS-1:0]        step,
    output logic signed [DW-1:0]         whole_n,
    output logic [COORD_BITS-1:0]        rem_n
  );
    logic signed [RW-1:0] sum;
    logic signed [RW-1:0] s;
    sum = RW'($signed({1'b0, rem})) + RW'(delta);
    s   = $signed({2'b00, step});
    if (sum >= s) begin
      sum     = sum - s;
      whole_n = whole + DW'(1);
    end else if (sum < 0) begin
      sum     = sum + s;
      whole_n = whole - DW'(1);
    end else begin
      whole_n = whole;
    end
    rem_n = sum[COORD_BITS-1:0];
  endfunction

  // Origin plus whole, nudged toward zero when a fraction is left over
  function automatic logic signed [RW-1:0] trunc_pos(
    input logic signed [COORD_BITS-1:0] org,
    input logic signed [DW-1:0]         whole,
    input logic [COORD_BITS-1:0]        rem
  );
    logic signed [RW-1:0] f;
    f = RW'(org) + RW'(whole);
    if (rem != '0 && f < 0) begin
      f = f + RW'(1);
    end
    return f;
  endfunction

  assign cmd_ready = !pix_valid || pix_ready;
  assign cmd_take  = cmd_valid && cmd_ready;

  // Load decode: deltas and step count
  always_comb begin
    ld_x0   = cmd.start_x[COORD_BITS-1:0];
    ld_y0   = cmd.start_y[COORD_BITS-1:0];
    ld_x1   = cmd.end_x[COORD_BITS-1:0];
    ld_y1   = cmd.end_y[COORD_BITS-1:0];
    ld_dx   = DW'(ld_x1) - DW'(ld_x0);
    ld_dy   = DW'(ld_y1) - DW'(ld_y0);
    ld_ax   = (ld_dx < 0) ? -ld_dx : ld_dx;
    ld_ay   = (ld_dy < 0) ? -ld_dy : ld_dy;
    ld_step = (ld_ax > ld_ay) ? ld_ax[COORD_BITS-1:0] : ld_ay[COORD_BITS-1:0];
  end

  // Advance: current pixel and next accumulator values
  always_comb begin
    accum(delta_x, whole_x, rem_x, step_total, whole_x_next, rem_x_next);
    accum(delta_y, whole_y, rem_y, step_total, whole_y_next, rem_y_next);
    pos_x    = trunc_pos(origin_x, whole_x, rem_x);
    pos_y    = trunc_pos(origin_y, whole_y, rem_y);
    is_last  = pixel_index >= step_total;
    pix_next = '0;
    if (line_active) begin
      pix_next.pixel_x     = 16'(pos_x);
      pix_next.pixel_y     = 16'(pos_y);
      pix_next.pixel_color = held_color;
      pix_next.pixel_valid = 1'b1;
      pix_next.last_pixel  = is_last;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      pix_valid   <= 1'b0;
    end else begin
      if (cmd_take && cmd.command == CMD_ADVANCE) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
      if (cmd_take) begin
        if (cmd.command == CMD_LOAD) begin
          line_active <= ld_step != '0;
        end else if (line_active && is_last) begin
          line_active <= 1'b0;
        end
      end
    end
  end

  // Line registers and output word
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      if (cmd.command == CMD_LOAD) begin
        origin_x    <= ld_x0;
        origin_y    <= ld_y0;
        delta_x     <= ld_dx;
        delta_y     <= ld_dy;
        step_total  <= ld_step;
        pixel_index <= '0;
        whole_x     <= '0;
        whole_y     <= '0;
        rem_x       <= '0;
        rem_y       <= '0;
        held_color  <= cmd.line_color;
      end else begin
        pix <= pix_next;
        if (line_active && !is_last) begin
          whole_x     <= whole_x_next;
          whole_y     <= whole_y_next;
          rem_x       <= rem_x_next;
          rem_y       <= rem_y_next;
          pixel_index <= pixel_index + COORD_BITS'(1);
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  // An active line always has a non-zero step count
  a_active_step: assert property (@(posedge clk) disable iff (rst)
    line_active |-> step_total != '0)
    else $error("active line with zero step count");

  // Remainders stay below the step count and the index never passes it
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    line_active |-> (rem_x < step_total && rem_y < step_total && pixel_index <= step_total))
    else $error("accumulator out of range");

  // An advance with no line gives an invalid pixel word next cycle
  a_idle_advance: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd.command == CMD_ADVANCE && !line_active)
      |=> (pix_valid && !pix.pixel_valid && !pix.last_pixel))
    else $error("idle advance did not give an invalid pixel");

  // Final pixel ends the line
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_take && cmd.command == CMD_ADVANCE && line_active && is_last) |=> !line_active)
    else $error("line still active after last pixel");
`endif

endmodule

[test/tb.sv]
// Self-checking testbench for the DDA line pixel generator, with its own line predictor.
module tb;
  import dda_pkg::*;

  localparam int COORD_W = 16;

  logic   clk = 1'b0;
  logic   rst;
  logic   cmd_valid;
  logic   cmd_ready;
  cmd_t   cmd;
  logic   pix_valid;
  logic   pix_ready;
  pixel_t pix;

  dda_line_pixel_generator #(
    .COORD_BITS(COORD_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .pix_valid(pix_valid),
    .pix_ready(pix_ready),
    .pix      (pix)
  );

  // 4-unit clock period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted pixel words, oldest first
  pixel_t pending_pixels[$];

  // Line tracer state
  int          line_org_x = 0;
  int          line_org_y = 0;
  int          line_dx = 0;
  int          line_dy = 0;
  int          line_steps = 0;
  int          line_pos = 0;
  int          acc_whole_x = 0;
  int          acc_frac_x = 0;
  int          acc_whole_y = 0;
  int          acc_frac_y = 0;
  bit          line_busy = 1'b0;
  logic [31:0] line_colour = '0;

  // Run control and tallies
  bit sender_idles = 1'b0;
  bit sink_idles = 1'b0;
  int sink_hold_cycles = 0;
  int requests_sent = 0;
  int pixels_checked = 0;
  int lines_finished = 0;
  int idle_results = 0;
  int mismatch_count = 0;

  // Low COORD_W bits read as two's complement
  function automatic int coord_of(logic [15:0] v);
    int u;
    u = int'(v) & ((1 << COORD_W) - 1);
    if (u >= (1 << (COORD_W - 1))) u -= (1 << COORD_W);
    return u;
  endfunction

  // origin + whole + frac/steps, truncated toward zero
  function automatic int round_to_zero(int org, int whole, int frac);
    int f;
    f = org + whole;
    if (frac != 0 && f < 0) f += 1;
    return f;
  endfunction

  // Move d*i = whole*steps + frac on to i+1; |d| never exceeds steps
  task automatic accumulate(input int d, inout int whole, inout int frac);
    int r;
    r = frac + d;
    if (r >= line_steps) begin
      r -= line_steps;
      whole += 1;
    end else if (r < 0) begin
      r += line_steps;
      whole -= 1;
    end
    frac = r;
  endtask

  // Update the tracer for one accepted request and queue any pixel it gives
  task automatic trace_line_request(input cmd_t c);
    pixel_t p;
    int     px, py, ax, ay;
    if (c.command == CMD_LOAD) begin
      line_org_x  = coord_of(c.start_x);
      line_org_y  = coord_of(c.start_y);
      line_dx     = coord_of(c.end_x) - line_org_x;
      line_dy     = coord_of(c.end_y) - line_org_y;
      ax          = (line_dx < 0) ? -line_dx : line_dx;
      ay          = (line_dy < 0) ? -line_dy : line_dy;
      line_steps  = (ax > ay) ? ax : ay;
      line_pos    = 0;
      acc_whole_x = 0;
      acc_frac_x  = 0;
      acc_whole_y = 0;
      acc_frac_y  = 0;
      line_colour = c.line_color;
      line_busy   = (line_steps != 0);
    end else begin
      p = '0;
      if (line_busy) begin
        px            = round_to_zero(line_org_x, acc_whole_x, acc_frac_x);
        py            = round_to_zero(line_org_y, acc_whole_y, acc_frac_y);
        p.pixel_x     = 16'(px);
        p.pixel_y     = 16'(py);
        p.pixel_color = line_colour;
        p.pixel_valid = 1'b1;
        p.last_pixel  = (line_pos >= line_steps);
        if (p.last_pixel) begin
          line_busy = 1'b0;
        end else begin
          accumulate(line_dx, acc_whole_x, acc_frac_x);
          accumulate(line_dy, acc_whole_y, acc_frac_y);
          line_pos += 1;
        end
      end
      pending_pixels.push_back(p);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 50)
      $display("ERROR %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
    mismatch_count++;
  endtask

  // Result checker: every accepted pixel word against the oldest prediction
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && pix_valid && pix_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel with no request outstanding", pix[31:0], '0);
      end else begin
        want = pending_pixels.pop_front();
        if (pix.pixel_x !== want.pixel_x)
          report_mismatch("pixel_x", 32'(pix.pixel_x), 32'(want.pixel_x));
        if (pix.pixel_y !== want.pixel_y)
          report_mismatch("pixel_y", 32'(pix.pixel_y), 32'(want.pixel_y));
        if (pix.pixel_color !== want.pixel_color)
          report_mismatch("pixel_color", pix.pixel_color, want.pixel_color);
        if (pix.pixel_valid !== want.pixel_valid)
          report_mismatch("pixel_valid", 32'(pix.pixel_valid), 32'(want.pixel_valid));
        if (pix.last_pixel !== want.last_pixel)
          report_mismatch("last_pixel", 32'(pix.last_pixel), 32'(want.last_pixel));
        pixels_checked++;
        if (!want.pixel_valid) idle_results++;
        if (want.last_pixel) lines_finished++;
      end
    end
  end

  // Downstream ready: random stall bursts, plus long holds on request
  initial begin : sink_drive
    int stall_left;
    stall_left = 0;
    pix_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_cycles > 0) begin
        stall_left       = sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (stall_left > 0) begin
        pix_ready <= 1'b0;
        stall_left--;
      end else if (sink_idles && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        pix_ready <= 1'b0;
      end else begin
        pix_ready <= 1'b1;
      end
    end
  end

  function automatic int clamp_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int random_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic cmd_t make_request(logic command, int sx, int sy, int ex, int ey,
                                        logic [31:0] colour);
    cmd_t c;
    c.command    = command;
    c.start_x    = 16'(sx);
    c.start_y    = 16'(sy);
    c.end_x      = 16'(ex);
    c.end_y      = 16'(ey);
    c.line_color = colour;
    return c;
  endfunction

  // Offer one request and hold it until accepted; valid is left high on return
  task automatic send_request(input cmd_t c);
    if (sender_idles && $urandom_range(0, 7) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (!cmd_ready);
    trace_line_request(c);
    requests_sent++;
  endtask

  task automatic send_load(input int sx, input int sy, input int ex, input int ey,
                           input logic [31:0] colour);
    send_request(make_request(CMD_LOAD, sx, sy, ex, ey, colour));
  endtask

  // Advances carry random coordinates and colour, which the block must ignore
  task automatic send_advances(input int count);
    repeat (count)
      send_request(make_request(CMD_ADVANCE, random_coord(), random_coord(), random_coord(),
                                random_coord(), $urandom));
  endtask

  // Stop offering and wait for every predicted pixel to come back
  task automatic drain_pixels();
    cmd_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  // One line: mostly short and drawn to the end, sometimes long, degenerate or cut short
  task automatic random_line_sequence();
    int sx, sy, ex, ey, kind, span, ax, ay, steps, n_adv;
    kind = $urandom_range(0, 99);
    sx   = random_coord();
    sy   = random_coord();
    if (kind < 80) begin
      span = $urandom_range(1, 12);
    end else if (kind < 85) begin
      span = $urandom_range(13, 300);
    end else begin
      span = 0;
    end
    if (kind >= 95) begin
      ex = sx;
      ey = sy;
    end else if (kind >= 85) begin
      ex = random_coord();
      ey = random_coord();
    end else begin
      ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
      ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
    end
    ax    = (ex > sx) ? ex - sx : sx - ex;
    ay    = (ey > sy) ? ey - sy : sy - ey;
    steps = (ax > ay) ? ax : ay;
    if (steps > 300 || $urandom_range(0, 9) >= 7) begin
      // broken off early: the next load replaces the line in progress
      n_adv = $urandom_range(0, (steps < 20) ? steps : 20);
    end else begin
      n_adv = steps + 1 + (($urandom_range(0, 3) == 0) ? 1 : 0);
    end
    send_load(sx, sy, ex, ey, $urandom);
    send_advances(n_adv);
  endtask

  // Advances straight after reset find no line
  task automatic test_idle_advances();
    send_advances(2);
  endtask

  // A line whose ends coincide gives no pixels
  task automatic test_zero_length();
    send_load(100, -200, 100, -200, 32'h0000_0000);
    send_advances(1);
  endtask

  // Short lines in different octants, each run to the end, the first also one beyond
  task automatic test_short_lines();
    send_load(0, 0, 3, -2, 32'hFFFF_FFFF);
    send_advances(5);
    send_load(-1, -1, -3, 2, 32'h1234_5678);
    send_advances(4);
  endtask

  // Corner to corner, then replaced mid-line by a line at the opposite extremes
  task automatic test_extreme_coords();
    send_load(-32768, -32768, 32767, 32767, 32'hA5A5_5A5A);
    send_advances(3);
    send_load(32767, -32768, 32765, -32767, 32'h0000_0001);
    send_advances(3);
  endtask

  // Downstream held off for a long stretch while advances keep coming
  task automatic test_output_backpressure();
    drain_pixels();
    sink_hold_cycles = 200;
    send_load(-10, 5, 50, 22, $urandom);
    send_advances(61);
  endtask

  task automatic test_random_lines(input int target);
    while (requests_sent < target) begin
      sender_idles = ($urandom_range(0, 7) != 0);
      sink_idles   = ($urandom_range(0, 7) != 0);
      random_line_sequence();
    end
  endtask

  // Sender goes quiet until all pixels are back, several times over
  task automatic test_pause_until_drained(input int target);
    while (requests_sent < target) begin
      random_line_sequence();
      drain_pixels();
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Closing stretch at full rate on both sides
  task automatic test_quiet_tail(input int target);
    sender_idles = 1'b0;
    sink_idles   = 1'b0;
    while (requests_sent < target) random_line_sequence();
  endtask

  initial begin
    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idles = 1'b1;
    sink_idles   = 1'b1;
    test_idle_advances();
    test_zero_length();
    test_short_lines();
    test_extreme_coords();
    test_output_backpressure();
    test_random_lines(1700);
    test_pause_until_drained(1850);
    test_quiet_tail(2000);

    drain_pixels();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests; checked %0d pixel words, %0d lines drawn to the end,",
             requests_sent, pixels_checked, lines_finished);
    $display("%0d advances with no line, %0d mismatches.", idle_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS dda_line_pixel_generator");
    end else begin
      $display("FAIL dda_line_pixel_generator");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL dda_line_pixel_generator");
    $finish;
  end

endmodule
